>>> src/ncr_pkg.sv
// shared types, constants and helpers for the nmea checksum rewriter
`default_nettype none
package ncr_pkg;

  localparam int LINE_BUFFER_DEF = 256;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // what the back end has to emit for one accepted input word
  localparam logic [1:0] CMD_PASS      = 2'd0;
  localparam logic [1:0] CMD_PASS_TAIL = 2'd1;
  localparam logic [1:0] CMD_TAIL      = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] sum;
  } cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> src/ncr_front.sv
// front end: chunk tracking, checksum and command classification
`default_nettype none
module ncr_front #(
  parameter int LINE_BUFFER = ncr_pkg::LINE_BUFFER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_byte,
  input  wire logic        q_full,
  output logic             push,
  output ncr_pkg::cmd_t    push_data
);
  import ncr_pkg::*;

  localparam int COL_W = $clog2(LINE_BUFFER);
  localparam logic [COL_W-1:0] LIMIT = COL_W'(LINE_BUFFER - 1);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_SENT  = 2'd1;
  localparam logic [1:0] PH_DROP  = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] col_inc;
  logic             full, accept, is_term, line_end, cmd_valid;
  logic [1:0]       cmd_kind;

  assign accept   = in_valid & ~q_full;
  assign col_inc  = ((phase_r == PH_START) ? '0 : col_r) + COL_W'(1);
  assign full     = (col_inc >= LIMIT);
  assign is_term  = (in_byte == CH_STAR) | (in_byte == CH_CR) |
                    (in_byte == CH_LF) | (in_byte == CH_NUL);
  assign line_end = (in_byte == CH_LF) | full;

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    cmd_valid = 1'b0;
    cmd_kind  = CMD_PASS;
    case (phase_r)
      PH_START: begin
        if (in_byte == CH_DOLLAR) begin
          xor_nxt   = 8'd0;
          cmd_valid = 1'b1;
          if (full) begin
            cmd_kind  = CMD_PASS_TAIL;
            phase_nxt = PH_START;
          end else begin
            phase_nxt = PH_SENT;
          end
        end else begin
          phase_nxt = line_end ? PH_START : PH_DROP;
        end
      end
      PH_SENT: begin
        cmd_valid = 1'b1;
        if (is_term) begin
          cmd_kind  = CMD_TAIL;
          phase_nxt = line_end ? PH_START : PH_DROP;
        end else begin
          xor_nxt = xor_r ^ in_byte;
          if (full) begin
            cmd_kind  = CMD_PASS_TAIL;
            phase_nxt = PH_START;
          end
        end
      end
      default: begin
        phase_nxt = line_end ? PH_START : PH_DROP;
      end
    endcase
    col_nxt = (phase_nxt == PH_START) ? '0 : col_inc;
  end

  assign push           = accept & cmd_valid;
  assign push_data.kind = cmd_kind;
  assign push_data.data = in_byte;
  assign push_data.sum  = xor_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      xor_r   <= 8'd0;
      col_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/ncr_queue.sv
// short command queue between front and back ends
`default_nettype none
module ncr_queue #(
  parameter int DEPTH = ncr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ncr_pkg::cmd_t push_data,
  input  wire logic          pop,
  output ncr_pkg::cmd_t      pop_data,
  output logic               empty,
  output logic               full
);
  import ncr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_FULL);
  assign pop_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("command queue underflow");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && !full) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue count did not follow a push");

endmodule
`default_nettype wire

>>> src/ncr_back.sv
// back end: expands commands into output words, one per cycle unless out_stall
`default_nettype none
module ncr_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ncr_pkg::cmd_t q_data,
  input  wire logic          q_empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_byte,
  output logic               out_run_last
);
  import ncr_pkg::*;

  localparam logic [2:0] STEP_BYTE = 3'd0;
  localparam logic [2:0] STEP_STAR = 3'd1;
  localparam logic [2:0] STEP_HI   = 3'd2;
  localparam logic [2:0] STEP_LO   = 3'd3;
  localparam logic [2:0] STEP_CR   = 3'd4;
  localparam logic [2:0] STEP_LF   = 3'd5;

  cmd_t       cmd_r;
  logic       busy_r;
  logic [2:0] step_r;
  logic [2:0] last_step;
  logic       take, done;

  assign last_step    = (cmd_r.kind == CMD_PASS) ? STEP_BYTE : STEP_LF;
  assign out_valid    = busy_r;
  assign out_run_last = (step_r == last_step);
  assign take         = busy_r & ~out_stall;
  assign done         = take & out_run_last;
  assign pop          = ~q_empty & (~busy_r | done);

  always_comb begin
    case (step_r)
      STEP_BYTE: out_byte = cmd_r.data;
      STEP_STAR: out_byte = CH_STAR;
      STEP_HI:   out_byte = hex_digit(cmd_r.sum[7:4]);
      STEP_LO:   out_byte = hex_digit(cmd_r.sum[3:0]);
      STEP_CR:   out_byte = CH_CR;
      default:   out_byte = CH_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_BYTE;
    end else if (pop) begin
      busy_r <= 1'b1;
      // a bare tail skips the pass-through word
      step_r <= (q_data.kind == CMD_TAIL) ? STEP_STAR : STEP_BYTE;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (take) begin
      step_r <= step_r + 3'd1;
    end
  end

  a_tail_ends_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_last && cmd_r.kind != CMD_PASS) |-> (out_byte == CH_LF))
    else $error("tail did not end with line feed");

endmodule
`default_nettype wire

>>> src/nmea_checksum_rewriter.sv
// nmea checksum rewriter: accepts one byte word per cycle while in_stall is
// low and emits the rewritten sentence stream. The front end takes an input
// word every cycle while its command queue (QUEUE_DEPTH entries) has room;
// each word gives zero or one command. Unless stalled, the back end drains
// commands at one output word per cycle: a pass-through gives its byte, a
// sentence end '*', two hex digits, CR and LF, a chunk-limit byte both.
// Sustained input rate is one word per cycle for sentence bodies and dropped
// text; the queue absorbs tail bursts, and in_stall rises only when it is full.
`default_nettype none
module nmea_checksum_rewriter #(
  parameter int LINE_BUFFER = ncr_pkg::LINE_BUFFER_DEF,
  parameter int QUEUE_DEPTH = ncr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last
);
  import ncr_pkg::*;

  cmd_t push_data, pop_data;
  logic push, pop, q_empty, q_full;

  assign in_stall = q_full;

  ncr_front #(.LINE_BUFFER(LINE_BUFFER)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ncr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  ncr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_data       (pop_data),
    .q_empty      (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule
`default_nettype wire
